// File: sv/vts_pkg.sv
// ----------------------------------------------------------------------------
// vts_pkg
// Shared types, register indexes and command codes of the vario tone
// scheduler: payload structs, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package vts_pkg;

    // configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN  = 3'd4;

    // variant codes
    localparam logic [1:0] VAR_FULL    = 2'd0;
    localparam logic [1:0] VAR_REDUCED = 2'd1;
    localparam logic [1:0] VAR_BUZZER  = 2'd2;

    // divider widths
    localparam int DIV_N_W = 16;
    localparam int DIV_D_W = 8;

    // divide operations issued by the controller
    localparam logic [2:0] DOP_NONE = 3'd0;
    localparam logic [2:0] DOP_LEN0 = 3'd1;  // full audio tone length
    localparam logic [2:0] DOP_Q1   = 3'd2;  // reduced audio span scale
    localparam logic [2:0] DOP_D1   = 3'd3;  // reduced audio scaled speed
    localparam logic [2:0] DOP_LEN1 = 3'd4;  // reduced audio tone length
    localparam logic [2:0] DOP_S2   = 3'd5;  // buzzer speed in dm/s
    localparam logic [2:0] DOP_I2   = 3'd6;  // buzzer interval

    // input item
    typedef struct packed {
        logic [15:0]        now;
        logic signed [15:0] climb_rate;
        logic               active;
    } t_in;

    // result item
    typedef struct packed {
        logic       beep;
        logic [7:0] tone_freq;
        logic [7:0] tone_length;
        logic       sinking;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic [2:0] div_op;
        logic       commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       act;
        logic [1:0] variant;
        logic       go0;      // full audio tone starts
        logic       pos0;     // full audio clamped speed is positive
        logic       go1;      // reduced audio tone starts
        logic       a_zero;   // buzzer speed rounds to zero
        logic       div_done;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/vts_div.sv
// ----------------------------------------------------------------------------
// vts_div
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Operands are latched at start; done pulses one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [vts_pkg::DIV_N_W-1:0] i_dividend,
    input  wire logic [vts_pkg::DIV_D_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [vts_pkg::DIV_N_W-1:0]      o_quotient
);

    localparam int NW    = vts_pkg::DIV_N_W;
    localparam int DW    = vts_pkg::DIV_D_W;
    localparam int STEPS = NW / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]   t1;
    logic [DW:0]   t2;
    logic          ge1;
    logic          ge2;
    logic [DW-1:0] rem1;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] quo1;
    logic [NW-1:0] n_quo;

    // two restoring steps per cycle
    always_comb begin
        t1    = {r_rem, r_quo[NW-1]};
        ge1   = (t1 >= {1'b0, r_dvs});
        rem1  = ge1 ? DW'(t1 - {1'b0, r_dvs}) : t1[DW-1:0];
        quo1  = {r_quo[NW-2:0], ge1};
        t2    = {rem1, quo1[NW-1]};
        ge2   = (t2 >= {1'b0, r_dvs});
        n_rem = ge2 ? DW'(t2 - {1'b0, r_dvs}) : t2[DW-1:0];
        n_quo = {quo1[NW-2:0], ge2};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: sv/vts_datapath.sv
// ----------------------------------------------------------------------------
// vts_datapath
// Configuration registers, input latch, tone timer, tone arithmetic and the
// shared divider. Forms and registers the result item on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire vts_pkg::t_in                   i_in_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [vts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire vts_pkg::t_cmd                  i_cmd,
    output vts_pkg::t_sts                       o_sts,
    output vts_pkg::t_out                       o_out_data
);

    // configuration and state
    logic [1:0]        r_variant;
    logic signed [4:0] r_cmin;
    logic signed [4:0] r_cmax;
    logic signed [3:0] r_smax;
    logic signed [3:0] r_smin;
    logic [15:0]       r_timer;

    // latched input item
    logic [15:0]        r_now;
    logic signed [15:0] r_v;
    logic               r_act;

    // divider results
    logic [2:0]  r_dop;
    logic        r_dneg;
    logic [7:0]  r_len;
    logic [4:0]  r_q;
    logic [14:0] r_d;
    logic [6:0]  r_a;
    logic [7:0]  r_ival;

    vts_pkg::t_out r_out;

    // divider connection
    logic [vts_pkg::DIV_N_W-1:0] div_dvd;
    logic [vts_pkg::DIV_D_W-1:0] div_dvs;
    logic                        div_neg;
    logic                        div_done;
    logic [vts_pkg::DIV_N_W-1:0] div_quo;

    vts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // thresholds and clamp limits
    logic signed [8:0]  cmin9;
    logic signed [8:0]  cmax9;
    logic signed [8:0]  emin9;
    logic signed [8:0]  emax9;
    logic signed [11:0] smax12;
    logic signed [11:0] smin12;
    logic signed [11:0] vmax12;
    logic signed [11:0] vmin12;
    logic signed [11:0] emax12;
    logic signed [11:0] span12;
    logic signed [16:0] v17;
    logic signed [16:0] emin17;
    logic signed [16:0] emax17;
    logic signed [16:0] vmax17;
    logic signed [16:0] vmin17;

    assign cmin9  = $signed({{4{r_cmin[4]}}, r_cmin});
    assign cmax9  = $signed({{4{r_cmax[4]}}, r_cmax});
    assign emin9  = cmin9 * 9'sd10 - 9'sd50;
    assign emax9  = cmax9 * 9'sd10 + 9'sd50;
    assign smax12 = $signed({{8{r_smax[3]}}, r_smax});
    assign smin12 = $signed({{8{r_smin[3]}}, r_smin});
    assign vmax12 = (smax12 + 12'sd10) * 12'sd100;
    assign vmin12 = (smin12 - 12'sd10) * 12'sd100;
    assign emax12 = $signed({{3{emax9[8]}}, emax9});
    assign span12 = vmax12 - emax12;
    assign v17    = $signed({r_v[15], r_v});
    assign emin17 = $signed({{8{emin9[8]}}, emin9});
    assign emax17 = $signed({{8{emax9[8]}}, emax9});
    assign vmax17 = $signed({{5{vmax12[11]}}, vmax12});
    assign vmin17 = $signed({{5{vmin12[11]}}, vmin12});

    // timer checks
    logic [15:0] timer_ahead;
    logic [15:0] since_beep;
    logic        due;

    assign timer_ahead = r_timer - r_now;
    assign since_beep  = r_now - r_timer;
    assign due         = timer_ahead[15];

    // full audio: clamp, pitch and length dividend
    logic               go0;
    logic               pos0;
    logic signed [11:0] s0;
    logic signed [15:0] s16;
    logic signed [15:0] f0t;
    logic signed [15:0] n0;
    logic [15:0]        n0_mag;

    assign go0 = (v17 < emin17) || ((v17 > emax17) && due);

    always_comb begin
        if (v17 > vmax17) begin
            s0 = vmax12;
        end else if (v17 < vmin17) begin
            s0 = vmin12;
        end else begin
            s0 = r_v[11:0];
        end
    end

    assign pos0   = (s0 > 12'sd0);
    assign s16    = $signed({{4{s0[11]}}, s0});
    assign f0t    = pos0 ? (s16 * 16'sd4 + 16'sd8000) : (s16 * 16'sd3 + 16'sd8000);
    assign n0     = 16'sd8000 - s16 * 16'sd5;
    assign n0_mag = n0[15] ? 16'(-n0) : 16'(n0);

    // reduced audio: speed above edge, clamped
    logic               ge1;
    logic               go1;
    logic signed [16:0] d_raw;
    logic [10:0]        dcl;
    logic [15:0]        dcl10;
    logic [7:0]         qdiv;
    logic signed [15:0] n1;
    logic [15:0]        n1_mag;
    logic [17:0]        f1t;

    assign ge1    = (v17 >= emax17);
    assign go1    = ge1 && due;
    assign d_raw  = v17 - emax17;
    assign dcl    = (d_raw > vmax17) ? vmax12[10:0] : d_raw[10:0];
    assign dcl10  = {5'd0, dcl} * 16'd10;
    assign qdiv   = (r_q == 5'd0) ? 8'd1 : {3'd0, r_q};
    assign n1     = 16'sd1600 - $signed({1'b0, r_d});
    assign n1_mag = n1[15] ? 16'(-n1) : 16'(n1);
    assign f1t    = {3'd0, r_d} * 18'd10 + 18'd16000;

    // buzzer: speed magnitude and interval
    logic [15:0] v_mag;
    logic        a_zero;
    logic [8:0]  ival;
    logic        beep2;

    assign v_mag  = r_v[15] ? 16'(-r_v) : 16'(r_v);
    assign a_zero = (r_a == 7'd0);
    assign ival   = a_zero ? 9'd300 : {1'b0, r_ival};
    assign beep2  = (since_beep > {7'd0, ival});

    // divider operand select
    always_comb begin
        div_dvd = '0;
        div_dvs = 8'd1;
        div_neg = 1'b0;
        case (i_cmd.div_op)
            vts_pkg::DOP_LEN0: begin
                div_dvd = n0_mag;
                div_dvs = 8'd100;
                div_neg = n0[15];
            end
            vts_pkg::DOP_Q1: begin
                div_dvd = {5'd0, span12[10:0]};
                div_dvs = 8'd100;
            end
            vts_pkg::DOP_D1: begin
                div_dvd = dcl10;
                div_dvs = qdiv;
            end
            vts_pkg::DOP_LEN1: begin
                div_dvd = n1_mag;
                div_dvs = 8'd100;
                div_neg = n1[15];
            end
            vts_pkg::DOP_S2: begin
                div_dvd = v_mag;
                div_dvs = 8'd10;
            end
            vts_pkg::DOP_I2: begin
                div_dvd = 16'd200;
                div_dvs = {1'b0, r_a};
            end
            default: begin
                div_dvd = '0;
                div_dvs = 8'd1;
            end
        endcase
    end

    // result forming
    vts_pkg::t_out res;
    logic [15:0]   n_timer;
    logic [7:0]    len0;

    assign len0 = pos0 ? r_len : 8'd20;

    always_comb begin
        res     = '0;
        n_timer = r_timer;
        if (!r_act) begin
            n_timer = r_now;
        end else begin
            case (r_variant)
                vts_pkg::VAR_FULL: begin
                    if (go0) begin
                        res.beep        = 1'b1;
                        res.tone_freq   = f0t[14:7];
                        res.tone_length = len0;
                        res.sinking     = r_v[15];
                        n_timer         = r_now + {9'd0, len0[7:1]};
                    end
                end
                vts_pkg::VAR_REDUCED: begin
                    if (go1) begin
                        res.beep        = 1'b1;
                        res.tone_freq   = f1t[15:8];
                        res.tone_length = r_len;
                        n_timer         = r_now + {7'd0, r_len, 1'b0};
                    end
                end
                vts_pkg::VAR_BUZZER: begin
                    if (beep2) begin
                        res.beep    = 1'b1;
                        res.sinking = !a_zero && r_v[15];
                        n_timer     = r_now;
                    end
                end
                default: begin
                    n_timer = r_timer;
                end
            endcase
        end
    end

    // configuration registers and tone timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= vts_pkg::VAR_FULL;
            r_cmin    <= '0;
            r_cmax    <= '0;
            r_smax    <= '0;
            r_smin    <= '0;
            r_timer   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vts_pkg::CFG_VARIANT:    r_variant <= i_cfg_data[1:0];
                    vts_pkg::CFG_CENTER_MIN: r_cmin    <= i_cfg_data[4:0];
                    vts_pkg::CFG_CENTER_MAX: r_cmax    <= i_cfg_data[4:0];
                    vts_pkg::CFG_SPEED_MAX:  r_smax    <= i_cfg_data[3:0];
                    vts_pkg::CFG_SPEED_MIN:  r_smin    <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_timer <= n_timer;
            end
        end
    end

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now <= i_in_data.now;
            r_v   <= i_in_data.climb_rate;
            r_act <= i_in_data.active;
        end
    end

    // divide bookkeeping and quotient capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dop  <= i_cmd.div_op;
            r_dneg <= div_neg;
        end
        if (div_done) begin
            case (r_dop)
                vts_pkg::DOP_LEN0,
                vts_pkg::DOP_LEN1: r_len  <= r_dneg ? (8'd0 - div_quo[7:0]) : div_quo[7:0];
                vts_pkg::DOP_Q1:   r_q    <= div_quo[4:0];
                vts_pkg::DOP_D1:   r_d    <= div_quo[14:0];
                vts_pkg::DOP_S2:   r_a    <= (div_quo > 16'd100) ? 7'd100 : div_quo[6:0];
                vts_pkg::DOP_I2:   r_ival <= div_quo[7:0];
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= res;
        end
    end

    assign o_out_data     = r_out;
    assign o_sts.act      = r_act;
    assign o_sts.variant  = r_variant;
    assign o_sts.go0      = go0;
    assign o_sts.pos0     = pos0;
    assign o_sts.go1      = go1;
    assign o_sts.a_zero   = a_zero;
    assign o_sts.div_done = div_done;

endmodule

`default_nettype wire

// File: sv/vts_ctrl.sv
// ----------------------------------------------------------------------------
// vts_ctrl
// Sequencer of the vario tone scheduler: accepts one item, walks the divide
// chain of the selected variant and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire vts_pkg::t_sts i_sts,
    output vts_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EVAL    = 4'd1;
    localparam logic [3:0] S_W_LEN0  = 4'd2;
    localparam logic [3:0] S_W_Q1    = 4'd3;
    localparam logic [3:0] S_GO_D1   = 4'd4;
    localparam logic [3:0] S_W_D1    = 4'd5;
    localparam logic [3:0] S_GO_LEN1 = 4'd6;
    localparam logic [3:0] S_W_LEN1  = 4'd7;
    localparam logic [3:0] S_W_S2    = 4'd8;
    localparam logic [3:0] S_GO_I2   = 4'd9;
    localparam logic [3:0] S_W_I2    = 4'd10;
    localparam logic [3:0] S_FINISH  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.div_op    = vts_pkg::DOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_FINISH;
                if (i_sts.act) begin
                    case (i_sts.variant)
                        vts_pkg::VAR_FULL: begin
                            if (i_sts.go0 && i_sts.pos0) begin
                                o_cmd.div_start = 1'b1;
                                o_cmd.div_op    = vts_pkg::DOP_LEN0;
                                n_state         = S_W_LEN0;
                            end
                        end
                        vts_pkg::VAR_REDUCED: begin
                            if (i_sts.go1) begin
                                o_cmd.div_start = 1'b1;
                                o_cmd.div_op    = vts_pkg::DOP_Q1;
                                n_state         = S_W_Q1;
                            end
                        end
                        vts_pkg::VAR_BUZZER: begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_op    = vts_pkg::DOP_S2;
                            n_state         = S_W_S2;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_W_LEN0: begin
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_W_Q1: begin
                if (i_sts.div_done) begin
                    n_state = S_GO_D1;
                end
            end
            S_GO_D1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = vts_pkg::DOP_D1;
                n_state         = S_W_D1;
            end
            S_W_D1: begin
                if (i_sts.div_done) begin
                    n_state = S_GO_LEN1;
                end
            end
            S_GO_LEN1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = vts_pkg::DOP_LEN1;
                n_state         = S_W_LEN1;
            end
            S_W_LEN1: begin
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_W_S2: begin
                if (i_sts.div_done) begin
                    n_state = S_GO_I2;
                end
            end
            S_GO_I2: begin
                if (i_sts.a_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = vts_pkg::DOP_I2;
                    n_state         = S_W_I2;
                end
            end
            S_W_I2: begin
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on commit, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sv/vario_tone_scheduler.sv
// ----------------------------------------------------------------------------
// vario_tone_scheduler
// Variometer tone decision per telemetry sample: beep, pitch, length, sink.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one sample with
//   its tick time and enable flag; a transfer happens when valid is high and
//   stall is low. Each sample yields exactly one result on the output channel
//   (o_out_valid / i_out_stall / o_out_data).
//   Configuration writes go through i_cfg_valid / o_cfg_ready with a register
//   index and data; ready is always high, writes are expected while idle.
//   Each sample runs its divides in turn on the shared two-bit-per-cycle
//   divider: one for a full audio climb tone, one or two for an active
//   buzzer sample, three for a reduced audio tone and none otherwise. One
//   sample is in work at a time; the next is taken once the sequencer is
//   back in idle.
//   A finished result sits in the output register; the next sample is taken
//   while it waits, and its own result waits in the sequencer until the
//   output register frees up.
//   Reset clears the configuration registers, the tone timer, the sequencer state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module vario_tone_scheduler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire vts_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output vts_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [vts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    vts_pkg::t_cmd cmd;
    vts_pkg::t_sts sts;
    logic          cfg_we;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    vts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vts_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
